### rtl/cdnu_pkg.sv
package cdnu_pkg;

    localparam int OP_W    = 3;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int SER_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int ORDER_W = 2;
    localparam int ACC_W   = 19;
    localparam int YLEN_W  = 9;
    localparam int PC_W    = 5;
    localparam int COND_W  = 4;
    localparam int UOP_W   = 4;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    localparam int DAY_RANGE_DEF = 73049;

    localparam logic [YEAR_W-1:0]  FIRST_YEAR  = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0]  LAST_YEAR   = YEAR_W'(2099);
    localparam logic [MONTH_W-1:0] FIRST_MONTH = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] LAST_MONTH  = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] MON_FEB     = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MON_APR     = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MON_JUN     = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MON_SEP     = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MON_NOV     = MONTH_W'(11);

    localparam logic [OP_W-1:0] OP_SET_DATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_SERIAL = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_DAYS   = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB_DAYS   = 3'd3;
    localparam logic [OP_W-1:0] OP_COMPARE    = 3'd4;

    localparam logic [ORDER_W-1:0] ORD_EARLIER = 2'd0;
    localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'd1;
    localparam logic [ORDER_W-1:0] ORD_LATER   = 2'd2;

    localparam logic [COND_W-1:0] C_ALWAYS    = 4'd0;
    localparam logic [COND_W-1:0] C_OP_DATE   = 4'd1;
    localparam logic [COND_W-1:0] C_OP_SER    = 4'd2;
    localparam logic [COND_W-1:0] C_NOT_ARITH = 4'd3;
    localparam logic [COND_W-1:0] C_DATE_BAD  = 4'd4;
    localparam logic [COND_W-1:0] C_YC_LT_IY  = 4'd5;
    localparam logic [COND_W-1:0] C_MC_LT_IM  = 4'd6;
    localparam logic [COND_W-1:0] C_ACC_GE_DR = 4'd7;
    localparam logic [COND_W-1:0] C_OP_CMP    = 4'd8;
    localparam logic [COND_W-1:0] C_TOD_YEAR  = 4'd9;
    localparam logic [COND_W-1:0] C_TOD_MONTH = 4'd10;

    localparam logic [UOP_W-1:0] U_NOP       = 4'd0;
    localparam logic [UOP_W-1:0] U_D_INIT    = 4'd1;
    localparam logic [UOP_W-1:0] U_SET_SER   = 4'd2;
    localparam logic [UOP_W-1:0] U_AR_SUM    = 4'd3;
    localparam logic [UOP_W-1:0] U_AR_WRAP   = 4'd4;
    localparam logic [UOP_W-1:0] U_AR_COMMIT = 4'd5;
    localparam logic [UOP_W-1:0] U_MARK_BAD  = 4'd6;
    localparam logic [UOP_W-1:0] U_YEAR_ADD  = 4'd7;
    localparam logic [UOP_W-1:0] U_MONTH_ADD = 4'd8;
    localparam logic [UOP_W-1:0] U_DAY_ADD   = 4'd9;
    localparam logic [UOP_W-1:0] U_COMPARE   = 4'd10;
    localparam logic [UOP_W-1:0] U_SET_DATE  = 4'd11;
    localparam logic [UOP_W-1:0] U_TOD_INIT  = 4'd12;
    localparam logic [UOP_W-1:0] U_YEAR_SUB  = 4'd13;
    localparam logic [UOP_W-1:0] U_MONTH_SUB = 4'd14;
    localparam logic [UOP_W-1:0] U_FINISH    = 4'd15;

    localparam logic [PC_W-1:0] PC_START   = 5'd0;
    localparam logic [PC_W-1:0] PC_AR_WRAP = 5'd4;
    localparam logic [PC_W-1:0] PC_AR_CMT  = 5'd5;
    localparam logic [PC_W-1:0] PC_DATE    = 5'd6;
    localparam logic [PC_W-1:0] PC_D_CHECK = 5'd7;
    localparam logic [PC_W-1:0] PC_D_YEAR  = 5'd8;
    localparam logic [PC_W-1:0] PC_D_MONTH = 5'd9;
    localparam logic [PC_W-1:0] PC_D_RANGE = 5'd11;
    localparam logic [PC_W-1:0] PC_D_STORE = 5'd12;
    localparam logic [PC_W-1:0] PC_TOD     = 5'd14;
    localparam logic [PC_W-1:0] PC_T_YEAR  = 5'd15;
    localparam logic [PC_W-1:0] PC_T_MONTH = 5'd16;
    localparam logic [PC_W-1:0] PC_FINISH  = 5'd17;

    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [DIFF_W-1:0] t_diff;

    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [UOP_W-1:0]  uop;
        logic [PC_W-1:0]   target;
    } t_uword;

    function automatic logic f_leap(input logic [YEAR_W-1:0] year);
        return (year[1:0] == 2'b00) && (year != FIRST_YEAR);
    endfunction

    function automatic logic [YLEN_W-1:0] f_year_len(input logic [YEAR_W-1:0] year);
        return f_leap(year) ? YLEN_W'(366) : YLEN_W'(365);
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic leap,
                                                     input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month)
            MON_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_W'(30);
            default: len = DAY_W'(31);
        endcase
        return len;
    endfunction

    function automatic t_uword f_urom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:  w = '{C_OP_DATE,   U_NOP,       PC_DATE};
            5'd1:  w = '{C_OP_SER,    U_SET_SER,   PC_TOD};
            5'd2:  w = '{C_NOT_ARITH, U_NOP,       PC_TOD};
            5'd3:  w = '{C_ALWAYS,    U_AR_SUM,    PC_AR_WRAP};
            5'd4:  w = '{C_ALWAYS,    U_AR_WRAP,   PC_AR_CMT};
            5'd5:  w = '{C_ALWAYS,    U_AR_COMMIT, PC_TOD};
            5'd6:  w = '{C_ALWAYS,    U_D_INIT,    PC_D_CHECK};
            5'd7:  w = '{C_DATE_BAD,  U_MARK_BAD,  PC_D_STORE};
            5'd8:  w = '{C_YC_LT_IY,  U_YEAR_ADD,  PC_D_YEAR};
            5'd9:  w = '{C_MC_LT_IM,  U_MONTH_ADD, PC_D_MONTH};
            5'd10: w = '{C_ALWAYS,    U_DAY_ADD,   PC_D_RANGE};
            5'd11: w = '{C_ACC_GE_DR, U_MARK_BAD,  PC_D_STORE};
            5'd12: w = '{C_OP_CMP,    U_COMPARE,   PC_TOD};
            5'd13: w = '{C_ALWAYS,    U_SET_DATE,  PC_TOD};
            5'd14: w = '{C_ALWAYS,    U_TOD_INIT,  PC_T_YEAR};
            5'd15: w = '{C_TOD_YEAR,  U_YEAR_SUB,  PC_T_YEAR};
            5'd16: w = '{C_TOD_MONTH, U_MONTH_SUB, PC_T_MONTH};
            5'd17: w = '{C_ALWAYS,    U_FINISH,    PC_START};
            default: w = '{C_ALWAYS,  U_NOP,       PC_START};
        endcase
        return w;
    endfunction

endpackage

### rtl/calendar_day_number_unit.sv
// Calendar day number unit: keeps one current date (1900-01-01 .. 2099-12-31)
// as a serial day count and runs one date operation per input transaction.
// Input channel s_axis: tuser carries the operation code, tdata its operands.
// Output channel m_axis: one result transaction per input transaction, with
// the current date as year/month/day and serial, the compare difference and
// order in tdata, and the error flag in tuser.
// One transaction is in work at a time; s_axis_tready is high while idle.
// The run time is set by the year stepping of the shared accumulator, one
// calendar year per cycle, once to build a serial from a date (set date and
// compare only) and once to split the current serial back into a date.
// The result sits in an output register; the next transaction is accepted
// while it waits. If m_axis_tready stays low, the sequencer holds at its
// final step until the output register frees up.
// Reset clears the sequencer and sets the current date to 1900-01-01
// (serial 0); no result is pending after reset.
module calendar_day_number_unit
    import cdnu_pkg::*;
#(
    parameter int DAY_RANGE = DAY_RANGE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // in_year[11:0], in_month[15:12], in_day[20:16], day_value[37:21]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation[2:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cur_year[11:0], cur_month[15:12], cur_day[20:16], cur_serial[37:21],
    // difference[55:38], order[57:56]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // error[0]
    output logic [0:0]            m_axis_tuser
);

    localparam t_acc LP_RANGE = t_acc'(DAY_RANGE);

    logic                  r_busy, n_busy;
    logic [PC_W-1:0]       r_pc, n_pc;
    logic [OP_W-1:0]       r_op, n_op;
    logic [YEAR_W-1:0]     r_iy, n_iy;
    logic [MONTH_W-1:0]    r_im, n_im;
    logic [DAY_W-1:0]      r_id, n_id;
    logic [SER_W-1:0]      r_dv, n_dv;
    t_acc                  r_acc, n_acc;
    logic [YEAR_W-1:0]     r_yc, n_yc;
    logic [MONTH_W-1:0]    r_mc, n_mc;
    logic [SER_W-1:0]      r_cur, n_cur;
    logic                  r_err, n_err;
    t_diff                 r_diff, n_diff;
    logic [ORDER_W-1:0]    r_order, n_order;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [0:0]            r_out_user, n_out_user;

    t_uword                w_uword;
    logic                  w_leap_in;
    logic                  w_leap_yc;
    logic [YLEN_W-1:0]     w_yl;
    logic [DAY_W-1:0]      w_ml_in;
    logic [DAY_W-1:0]      w_ml_yc;
    logic [DAY_W-1:0]      w_ml_given;
    logic                  w_date_bad;
    logic                  w_cond;
    logic                  w_hold;
    logic                  w_step;
    logic                  w_take;
    logic                  w_accept;
    t_diff                 w_diff;

    assign w_uword    = f_urom(r_pc);
    assign w_leap_in  = f_leap(r_iy);
    assign w_leap_yc  = f_leap(r_yc);
    assign w_yl       = f_year_len(r_yc);
    assign w_ml_in    = f_month_len(w_leap_in, r_mc);
    assign w_ml_yc    = f_month_len(w_leap_yc, r_mc);
    assign w_ml_given = f_month_len(w_leap_in, r_im);

    assign w_date_bad = (r_iy < FIRST_YEAR) || (r_iy > LAST_YEAR) ||
                        (r_im < FIRST_MONTH) || (r_im > LAST_MONTH) ||
                        (r_id == '0) || (r_id > w_ml_given);

    assign w_diff = t_diff'(DIFF_W'(r_cur)) - t_diff'(DIFF_W'(r_acc[SER_W-1:0]));

    always_comb begin
        case (w_uword.cond)
            C_ALWAYS:    w_cond = 1'b1;
            C_OP_DATE:   w_cond = r_op inside {OP_SET_DATE, OP_COMPARE};
            C_OP_SER:    w_cond = (r_op == OP_SET_SERIAL);
            C_NOT_ARITH: w_cond = !(r_op inside {OP_ADD_DAYS, OP_SUB_DAYS});
            C_DATE_BAD:  w_cond = w_date_bad;
            C_YC_LT_IY:  w_cond = (r_yc < r_iy);
            C_MC_LT_IM:  w_cond = (r_mc < r_im);
            C_ACC_GE_DR: w_cond = (r_acc >= LP_RANGE);
            C_OP_CMP:    w_cond = (r_op == OP_COMPARE);
            C_TOD_YEAR:  w_cond = (r_yc < LAST_YEAR) && (r_acc >= t_acc'(ACC_W'(w_yl)));
            C_TOD_MONTH: w_cond = (r_mc < LAST_MONTH) && (r_acc >= t_acc'(ACC_W'(w_ml_yc)));
            default:     w_cond = 1'b0;
        endcase
    end

    assign w_hold   = (w_uword.uop == U_FINISH) && r_out_valid && !m_axis_tready;
    assign w_step   = r_busy && !w_hold;
    assign w_take   = w_step && w_cond;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_op        = r_op;
        n_iy        = r_iy;
        n_im        = r_im;
        n_id        = r_id;
        n_dv        = r_dv;
        n_acc       = r_acc;
        n_yc        = r_yc;
        n_mc        = r_mc;
        n_cur       = r_cur;
        n_err       = r_err;
        n_diff      = r_diff;
        n_order     = r_order;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_accept) begin
            n_busy  = 1'b1;
            n_pc    = PC_START;
            n_op    = s_axis_tuser;
            n_iy    = s_axis_tdata[11:0];
            n_im    = s_axis_tdata[15:12];
            n_id    = s_axis_tdata[20:16];
            n_dv    = s_axis_tdata[37:21];
            n_err   = 1'b0;
            n_diff  = '0;
            n_order = ORD_EARLIER;
        end

        if (w_step) begin
            n_pc = w_take ? w_uword.target : PC_W'(r_pc + 1'b1);
        end

        if (w_take) begin
            case (w_uword.uop)
                U_NOP: begin
                end
                U_D_INIT: begin
                    n_acc = '0;
                    n_yc  = FIRST_YEAR;
                    n_mc  = FIRST_MONTH;
                end
                U_SET_SER: begin
                    if (t_acc'(ACC_W'(r_dv)) < LP_RANGE) begin
                        n_cur = r_dv;
                    end else begin
                        n_cur = '0;
                        n_err = 1'b1;
                    end
                end
                U_AR_SUM: begin
                    if (r_op == OP_ADD_DAYS) begin
                        n_acc = t_acc'(ACC_W'(r_cur)) + t_acc'(ACC_W'(r_dv));
                    end else begin
                        n_acc = t_acc'(ACC_W'(r_cur)) - t_acc'(ACC_W'(r_dv));
                    end
                end
                U_AR_WRAP: begin
                    if (r_op == OP_ADD_DAYS) begin
                        if (r_acc >= LP_RANGE) begin
                            n_acc = r_acc - LP_RANGE;
                        end
                    end else if (r_acc < 0) begin
                        n_acc = r_acc + LP_RANGE;
                    end
                end
                U_AR_COMMIT: begin
                    if ((r_acc >= 0) && (r_acc < LP_RANGE)) begin
                        n_cur = r_acc[SER_W-1:0];
                    end else begin
                        n_cur = '0;
                        n_err = 1'b1;
                    end
                end
                U_MARK_BAD: begin
                    n_acc = '0;
                    n_err = 1'b1;
                end
                U_YEAR_ADD: begin
                    n_acc = r_acc + t_acc'(ACC_W'(w_yl));
                    n_yc  = YEAR_W'(r_yc + 1'b1);
                end
                U_MONTH_ADD: begin
                    n_acc = r_acc + t_acc'(ACC_W'(w_ml_in));
                    n_mc  = MONTH_W'(r_mc + 1'b1);
                end
                U_DAY_ADD: begin
                    n_acc = r_acc + t_acc'(ACC_W'(r_id)) - t_acc'(1);
                end
                U_COMPARE: begin
                    n_diff = w_diff;
                    if (w_diff < 0) begin
                        n_order = ORD_EARLIER;
                    end else if (w_diff == 0) begin
                        n_order = ORD_EQUAL;
                    end else begin
                        n_order = ORD_LATER;
                    end
                end
                U_SET_DATE: begin
                    n_cur = r_acc[SER_W-1:0];
                end
                U_TOD_INIT: begin
                    n_acc = t_acc'(ACC_W'(r_cur));
                    n_yc  = FIRST_YEAR;
                    n_mc  = FIRST_MONTH;
                end
                U_YEAR_SUB: begin
                    n_acc = r_acc - t_acc'(ACC_W'(w_yl));
                    n_yc  = YEAR_W'(r_yc + 1'b1);
                end
                U_MONTH_SUB: begin
                    n_acc = r_acc - t_acc'(ACC_W'(w_ml_yc));
                    n_mc  = MONTH_W'(r_mc + 1'b1);
                end
                U_FINISH: begin
                    n_busy      = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_data  = {6'b0, r_order, r_diff, r_cur,
                                   DAY_W'(r_acc[DAY_W-1:0] + 1'b1), r_mc, r_yc};
                    n_out_user  = r_err;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_START;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_iy       <= n_iy;
        r_im       <= n_im;
        r_id       <= n_id;
        r_dv       <= n_dv;
        r_acc      <= n_acc;
        r_yc       <= n_yc;
        r_mc       <= n_mc;
        r_err      <= n_err;
        r_diff     <= n_diff;
        r_order    <= n_order;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_busy && (r_pc == PC_START))
        else $error("accepted transaction did not start the sequencer");

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_acc'(ACC_W'(r_cur)) < LP_RANGE)
        else $error("current serial outside day range");

    a_finish_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && (w_uword.uop == U_FINISH) |=> m_axis_tvalid && !r_busy)
        else $error("final step did not post a result");

    a_equal_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[57:56] == ORD_EQUAL) |-> (m_axis_tdata[55:38] == '0))
        else $error("equal order with nonzero difference");

endmodule

### test/calendar_day_number_unit_tb.sv
`timescale 1ns / 1ps

module calendar_day_number_unit_tb
    import cdnu_pkg::*;
();

    localparam int STALL_PCT      = 36;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 500;
    localparam int SPAN_DAYS      = 73049;
    localparam int VALUE_MAX      = 131071;
    localparam int SHOWN_MAX      = 10;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [SER_W-1:0]   serial;
        logic               error;
        logic [DIFF_W-1:0]  diff;
        logic [ORDER_W-1:0] order;
    } t_date_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // in_year[11:0], in_month[15:12], in_day[20:16], day_value[37:21]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // operation[2:0]
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // cur_year[11:0], cur_month[15:12], cur_day[20:16], cur_serial[37:21],
    // difference[55:38], order[57:56]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // error[0]
    logic [0:0]            m_axis_tuser;

    int           model_serial = 0;
    t_date_result expected_dates[$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           quiet_run = 1'b0;

    calendar_day_number_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_year(input int y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int days_in_month(input int y, input int m);
        int len;
        case (m)
            2: len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default: len = 31;
        endcase
        return len;
    endfunction

    function automatic bit day_number_ok(input longint s);
        return (s >= 0) && (s < DAY_RANGE_DEF) && (s < SPAN_DAYS);
    endfunction

    function automatic bit date_to_day_number(input int y, input int m, input int d,
                                              output int serial);
        int acc;
        acc = 0;
        serial = 0;
        if (y < 1900 || y > 2099 || m < 1 || m > 12)
            return 1'b0;
        if (d < 1 || d > days_in_month(y, m))
            return 1'b0;
        for (int k = 1900; k < y; k++)
            acc += days_in_year(k);
        for (int k = 1; k < m; k++)
            acc += days_in_month(y, k);
        acc += d - 1;
        if (!day_number_ok(acc))
            return 1'b0;
        serial = acc;
        return 1'b1;
    endfunction

    function automatic t_date_result apply_calendar_op(input logic [OP_W-1:0] op,
                                                       input int y, input int m,
                                                       input int d, input int value);
        t_date_result r;
        longint       t;
        longint       delta;
        int           given;
        int           rest;
        int           yy;
        int           mm;
        bit           bad;
        bad = 1'b0;
        delta = 0;
        given = 0;
        r.order = ORD_EARLIER;
        case (op)
            OP_SET_DATE: begin
                if (date_to_day_number(y, m, d, given)) begin
                    model_serial = given;
                end else begin
                    model_serial = 0;
                    bad = 1'b1;
                end
            end
            OP_SET_SERIAL: begin
                if (day_number_ok(value)) begin
                    model_serial = value;
                end else begin
                    model_serial = 0;
                    bad = 1'b1;
                end
            end
            OP_ADD_DAYS: begin
                t = longint'(model_serial) + value;
                if (t >= DAY_RANGE_DEF)
                    t -= DAY_RANGE_DEF;
                if (day_number_ok(t)) begin
                    model_serial = int'(t);
                end else begin
                    model_serial = 0;
                    bad = 1'b1;
                end
            end
            OP_SUB_DAYS: begin
                t = longint'(model_serial) - value;
                if (t < 0)
                    t += DAY_RANGE_DEF;
                if (day_number_ok(t)) begin
                    model_serial = int'(t);
                end else begin
                    model_serial = 0;
                    bad = 1'b1;
                end
            end
            OP_COMPARE: begin
                if (!date_to_day_number(y, m, d, given)) begin
                    given = 0;
                    bad = 1'b1;
                end
                delta = longint'(model_serial) - given;
                r.order = (delta < 0) ? ORD_EARLIER : ((delta == 0) ? ORD_EQUAL : ORD_LATER);
            end
            default: ;
        endcase
        rest = model_serial;
        yy = 1900;
        mm = 1;
        while (yy < 2099 && rest >= days_in_year(yy)) begin
            rest -= days_in_year(yy);
            yy++;
        end
        while (mm < 12 && rest >= days_in_month(yy, mm)) begin
            rest -= days_in_month(yy, mm);
            mm++;
        end
        r.year = YEAR_W'(yy);
        r.month = MONTH_W'(mm);
        r.day = DAY_W'(rest + 1);
        r.serial = SER_W'(model_serial);
        r.error = bad;
        r.diff = DIFF_W'(delta);
        return r;
    endfunction

    task automatic send_date_op(input logic [OP_W-1:0] op, input int y, input int m,
                                input int d, input int value);
        int yv;
        int mv;
        int dv;
        int vv;
        yv = y & 32'hFFF;
        mv = m & 32'hF;
        dv = d & 32'h1F;
        vv = value & 32'h1FFFF;
        while (!quiet_run && $urandom_range(99) < STALL_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, SER_W'(vv), DAY_W'(dv), MONTH_W'(mv), YEAR_W'(yv)};
        expected_dates.push_back(apply_calendar_op(op, yv, mv, dv, vv));
        do
            @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        if (mismatch_count < SHOWN_MAX)
            $display("mismatch %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
        mismatch_count++;
    endtask

    task automatic check_date_result();
        t_date_result want;
        t_date_result got;
        got.year = m_axis_tdata[11:0];
        got.month = m_axis_tdata[15:12];
        got.day = m_axis_tdata[20:16];
        got.serial = m_axis_tdata[37:21];
        got.diff = m_axis_tdata[55:38];
        got.order = m_axis_tdata[57:56];
        got.error = m_axis_tuser[0];
        if (expected_dates.size() == 0) begin
            flag_mismatch("unexpected transaction, serial", -1, got.serial);
        end else begin
            want = expected_dates.pop_front();
            if (got.year !== want.year)
                flag_mismatch("cur_year", want.year, got.year);
            if (got.month !== want.month)
                flag_mismatch("cur_month", want.month, got.month);
            if (got.day !== want.day)
                flag_mismatch("cur_day", want.day, got.day);
            if (got.serial !== want.serial)
                flag_mismatch("cur_serial", want.serial, got.serial);
            if (got.error !== want.error)
                flag_mismatch("error", want.error, got.error);
            if (got.diff !== want.diff)
                flag_mismatch("difference", $signed(want.diff), $signed(got.diff));
            if (got.order !== want.order)
                flag_mismatch("order", want.order, got.order);
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= quiet_run || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                    idle_cycles <= 0;
                else
                    idle_cycles <= idle_cycles + 1;
                if (m_axis_tvalid && m_axis_tready)
                    check_date_result();
            end
        end
    end

    task automatic test_set_date_edges();
        send_date_op(OP_SET_DATE, 1900, 1, 1, 0);
        send_date_op(OP_SET_DATE, 2099, 12, 31, 0);
        send_date_op(OP_SET_DATE, 2000, 2, 29, 0);
        send_date_op(OP_SET_DATE, 1900, 2, 29, 0);
        send_date_op(OP_SET_DATE, 2100, 1, 1, 0);
        send_date_op(OP_SET_DATE, 1899, 12, 31, 0);
        send_date_op(OP_SET_DATE, 2023, 13, 1, 0);
        send_date_op(OP_SET_DATE, 2023, 4, 31, 0);
        send_date_op(OP_SET_DATE, 4095, 15, 31, VALUE_MAX);
        send_date_op(OP_SET_DATE, 0, 0, 0, 0);
    endtask

    task automatic test_set_serial_edges();
        send_date_op(OP_SET_SERIAL, 0, 0, 0, 364);
        send_date_op(OP_SET_SERIAL, 0, 0, 0, SPAN_DAYS - 1);
        send_date_op(OP_SET_SERIAL, 0, 0, 0, SPAN_DAYS);
        send_date_op(OP_SET_SERIAL, 0, 0, 0, VALUE_MAX);
    endtask

    task automatic test_add_sub_wrap();
        send_date_op(OP_SUB_DAYS, 0, 0, 0, 1);
        send_date_op(OP_ADD_DAYS, 0, 0, 0, VALUE_MAX);
        send_date_op(OP_SUB_DAYS, 0, 0, 0, VALUE_MAX);
        send_date_op(OP_ADD_DAYS, 0, 0, 0, 59);
        send_date_op(OP_SUB_DAYS, 0, 0, 0, 0);
    endtask

    task automatic test_compare_order();
        send_date_op(OP_COMPARE, 1900, 3, 1, 0);
        send_date_op(OP_COMPARE, 2099, 12, 31, 0);
        send_date_op(OP_COMPARE, 1900, 1, 1, 0);
        send_date_op(OP_COMPARE, 1900, 2, 29, 0);
    endtask

    task automatic test_unused_codes();
        for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
            send_date_op(OP_W'(op), 4095, 15, 31, VALUE_MAX);
    endtask

    task automatic send_random_date_op();
        logic [OP_W-1:0] op;
        int pick;
        int y;
        int m;
        int d;
        int value;
        pick = $urandom_range(99);
        if (pick < 20)
            op = OP_SET_DATE;
        else if (pick < 35)
            op = OP_SET_SERIAL;
        else if (pick < 55)
            op = OP_ADD_DAYS;
        else if (pick < 75)
            op = OP_SUB_DAYS;
        else if (pick < 93)
            op = OP_COMPARE;
        else
            op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        pick = $urandom_range(99);
        if (pick < 85) begin
            y = (pick < 75) ? $urandom_range(2099, 1900)
                            : (($urandom_range(1)) ? 1900 : 2099);
            m = $urandom_range(12, 1);
            d = (pick < 60) ? $urandom_range(days_in_month(y, m), 1) : days_in_month(y, m);
        end else begin
            y = $urandom_range(4095);
            m = $urandom_range(15);
            d = $urandom_range(31);
        end
        pick = $urandom_range(99);
        if (pick < 45)
            value = $urandom_range(400);
        else if (pick < 75)
            value = $urandom_range(SPAN_DAYS - 1);
        else if (pick < 90)
            value = $urandom_range(SPAN_DAYS + 8, SPAN_DAYS - 8);
        else
            value = $urandom_range(VALUE_MAX);
        send_date_op(op, y, m, d, value);
    endtask

    task automatic test_random_mix(input int count);
        quiet_run = 1'b0;
        repeat (count) send_random_date_op();
    endtask

    task automatic test_back_to_back(input int count);
        quiet_run = 1'b1;
        repeat (count) send_random_date_op();
        quiet_run = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_set_date_edges();
        test_set_serial_edges();
        test_add_sub_wrap();
        test_compare_order();
        test_unused_codes();
        test_random_mix(400);
        test_back_to_back(200);
        test_random_mix(325);
        s_axis_tvalid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_dates.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
